[rtl/llrp_pkg.sv]
// shared types and constants for the least-loaded row packer
package llrp_pkg;

  // row store geometry
  localparam int unsigned MAX_ROWS  = 256;
  localparam int unsigned ROW_IDX_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int unsigned ROW_CNT_W = $clog2(MAX_ROWS + 1);

  // field widths
  localparam int unsigned GLYPH_W   = 10;
  localparam int unsigned PAD_W     = 8;
  localparam int unsigned NROWS_W   = 9;
  localparam int unsigned WIDTH_W   = 20;
  localparam int unsigned ROW_OUT_W = 8;
  localparam int unsigned SUM_W     = WIDTH_W + 2;

  localparam logic [WIDTH_W-1:0] WIDTH_MAX = {WIDTH_W{1'b1}};

  // configuration port
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = NROWS_W;
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_ROWS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_PAD      = 1'b1;

  typedef struct packed {
    logic [GLYPH_W-1:0] glyph_width;
    logic               first_item;
  } in_req_t;

  typedef struct packed {
    logic [ROW_OUT_W-1:0] row_index;
    logic [WIDTH_W-1:0]   x_offset;
    logic [WIDTH_W-1:0]   max_row_width;
  } out_req_t;

  // write request into the row store
  typedef struct packed {
    logic                 en;
    logic [ROW_IDX_W-1:0] addr;
    logic [WIDTH_W-1:0]   data;
  } row_wr_t;

endpackage

[rtl/least_loaded_row_packer_core.sv]
// least-loaded row packer: top level with scan sequencer and output register
//
// usage
// - in channel (in_valid_i / in_ready_o / in_req_i): one glyph width per
//   request; first_item set starts a new packing, all rows and the running
//   maximum go back to the padding value before the glyph is placed
// - out channel (out_valid_o / out_ready_i / out_req_o): one result per
//   request with the chosen row, the x offset and the widest row so far
// - cfg port: cfg_we_i writes cfg_data_i into register cfg_idx_i
//   (num_rows, pad_pixels) in the same cycle; write only while idle
// - timing: the row widths sit in a one-port-read memory, read one row a
//   cycle, so a request scans every row in use before its result is
//   registered; the next request is accepted only once the write-back
//   has returned the sequencer to idle
// - the result register lets the next request be accepted while a result
//   still waits; a stalled receiver only blocks the following write-back
// - reset: num_rows = 1, pad_pixels = 0, every row and the maximum read as
//   zero; the clear is done with valid bits, so no sweep is needed
module least_loaded_row_packer_core (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [llrp_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [llrp_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  llrp_pkg::in_req_t                  in_req_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output llrp_pkg::out_req_t                 out_req_o
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_WRITE = 2'd2;

  // configuration registers
  logic [llrp_pkg::NROWS_W-1:0] num_rows_q;
  logic [llrp_pkg::PAD_W-1:0]   pad_q;

  // sequencer
  logic [1:0]                     state_q, state_d;
  logic [llrp_pkg::GLYPH_W-1:0]   glyph_q;
  logic [llrp_pkg::ROW_CNT_W-1:0] rd_idx_q;
  logic [llrp_pkg::ROW_CNT_W-1:0] rows_used;
  logic                           cmp_vld_q;
  logic [llrp_pkg::ROW_IDX_W-1:0] cmp_idx_q;
  logic [llrp_pkg::ROW_IDX_W-1:0] best_idx_q;
  logic [llrp_pkg::WIDTH_W-1:0]   best_val_q;
  logic [llrp_pkg::WIDTH_W-1:0]   widest_q;

  // output register
  logic               out_valid_q;
  llrp_pkg::out_req_t out_q;

  // row store hookup
  logic                           in_fire;
  logic                           rd_en;
  logic                           scan_done;
  logic                           wb_fire;
  logic [llrp_pkg::WIDTH_W-1:0]   rd_data;
  logic [llrp_pkg::SUM_W-1:0]     sum;
  logic [llrp_pkg::WIDTH_W-1:0]   grown;
  logic [llrp_pkg::WIDTH_W-1:0]   widest_new;
  llrp_pkg::row_wr_t              row_wr;

  // a row count of zero means one row, anything above the store depth is clipped
  always_comb begin
    priority if (num_rows_q == '0) begin
      rows_used = llrp_pkg::ROW_CNT_W'(1);
    end else if (32'(num_rows_q) > llrp_pkg::MAX_ROWS) begin
      rows_used = llrp_pkg::ROW_CNT_W'(llrp_pkg::MAX_ROWS);
    end else begin
      rows_used = llrp_pkg::ROW_CNT_W'(num_rows_q);
    end
  end

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign rd_en      = (state_q == ST_SCAN) && (rd_idx_q != rows_used);
  assign scan_done  = (state_q == ST_SCAN) && (rd_idx_q == rows_used) && !cmp_vld_q;
  // write-back waits until the result register is free
  assign wb_fire    = (state_q == ST_WRITE) && (!out_valid_q || out_ready_i);

  // saturating add of glyph and padding onto the least loaded row
  assign sum = llrp_pkg::SUM_W'(best_val_q) + llrp_pkg::SUM_W'(glyph_q)
             + llrp_pkg::SUM_W'(pad_q);
  assign grown = (sum > llrp_pkg::SUM_W'(llrp_pkg::WIDTH_MAX)) ? llrp_pkg::WIDTH_MAX
                                                              : sum[llrp_pkg::WIDTH_W-1:0];
  assign widest_new = (grown > widest_q) ? grown : widest_q;

  always_comb begin
    row_wr.en   = wb_fire;
    row_wr.addr = best_idx_q;
    row_wr.data = grown;
  end

  llrp_row_store u_row_store (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .clear_i     (in_fire && in_req_i.first_item),
    .clear_val_i (llrp_pkg::WIDTH_W'(pad_q)),
    .rd_en_i     (rd_en),
    .rd_addr_i   (rd_idx_q[llrp_pkg::ROW_IDX_W-1:0]),
    .rd_data_o   (rd_data),
    .wr_i        (row_wr)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (in_fire)   state_d = ST_SCAN;
      ST_SCAN:  if (scan_done) state_d = ST_WRITE;
      ST_WRITE: if (wb_fire)   state_d = ST_IDLE;
      default:                 state_d = ST_IDLE;
    endcase
  end

  // config writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_rows_q <= llrp_pkg::NROWS_W'(1);
      pad_q      <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        llrp_pkg::CFG_NUM_ROWS: num_rows_q <= cfg_data_i;
        llrp_pkg::CFG_PAD:      pad_q      <= cfg_data_i[llrp_pkg::PAD_W-1:0];
        default: ;
      endcase
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      rd_idx_q    <= '0;
      cmp_vld_q   <= 1'b0;
      widest_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (in_fire) begin
        rd_idx_q <= '0;
        if (in_req_i.first_item) begin
          widest_q <= llrp_pkg::WIDTH_W'(pad_q);
        end
      end else if (rd_en) begin
        rd_idx_q <= rd_idx_q + llrp_pkg::ROW_CNT_W'(1);
      end
      cmp_vld_q <= rd_en;
      if (wb_fire) begin
        widest_q <= widest_new;
      end
      if (wb_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // scan datapath: row 0 seeds the minimum, strictly smaller wins so ties keep the lower row
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      glyph_q <= in_req_i.glyph_width;
    end
    if (rd_en) begin
      cmp_idx_q <= rd_idx_q[llrp_pkg::ROW_IDX_W-1:0];
    end
    if (cmp_vld_q && ((cmp_idx_q == '0) || (rd_data < best_val_q))) begin
      best_idx_q <= cmp_idx_q;
      best_val_q <= rd_data;
    end
    if (wb_fire) begin
      out_q.row_index     <= llrp_pkg::ROW_OUT_W'(best_idx_q);
      out_q.x_offset      <= best_val_q;
      out_q.max_row_width <= widest_new;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_req_o   = out_q;

endmodule

[rtl/llrp_row_store.sv]
// row width memory with per-row valid bits and a bulk clear value
module llrp_row_store (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             clear_i,
  input  logic [llrp_pkg::WIDTH_W-1:0]     clear_val_i,
  input  logic                             rd_en_i,
  input  logic [llrp_pkg::ROW_IDX_W-1:0]   rd_addr_i,
  output logic [llrp_pkg::WIDTH_W-1:0]     rd_data_o,
  input  llrp_pkg::row_wr_t                wr_i
);

  logic [llrp_pkg::WIDTH_W-1:0] mem [llrp_pkg::MAX_ROWS];
  logic [llrp_pkg::MAX_ROWS-1:0] valid_q;
  logic [llrp_pkg::WIDTH_W-1:0]  clear_val_q;
  logic [llrp_pkg::WIDTH_W-1:0]  rd_q;
  logic                          rd_hit_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.data;
    end
    if (rd_en_i) begin
      rd_q <= mem[rd_addr_i];
    end
  end

  // a row never written since the last clear reads as the clear value
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= '0;
      clear_val_q <= '0;
      rd_hit_q    <= 1'b0;
    end else begin
      if (clear_i) begin
        valid_q     <= '0;
        clear_val_q <= clear_val_i;
      end else if (wr_i.en) begin
        valid_q[wr_i.addr] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_hit_q <= valid_q[rd_addr_i];
      end
    end
  end

  assign rd_data_o = rd_hit_q ? rd_q : clear_val_q;

endmodule
